// ===== hdl/aslf_pkg.sv =====
// Types, codes and constants shared by the timestamped log FIFO.
// No dependencies; every other file refers to this package by scoped names.
package aslf_pkg;

    localparam int SEQ_W      = 16;
    localparam int IN_TIME_W  = 48;
    localparam int CNT_OUT_W  = 10;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int ENT_W      = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'd1;

    localparam logic [IN_TIME_W-1:0] MAX_AGE_RESET     = 48'd5000000;
    localparam logic [ENT_W-1:0]     MAX_ENTRIES_RESET = 10'd500;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [SEQ_W-1:0]     seq_in;
        logic [IN_TIME_W-1:0] now_us;
    } in_t;

    typedef struct packed {
        logic                 entry_valid;
        logic [SEQ_W-1:0]     seq_out;
        logic [IN_TIME_W-1:0] time_out;
        logic                 last_entry;
        logic [CNT_OUT_W-1:0] held_count;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AGE_RD,
        ST_AGE_CMP,
        ST_STORE,
        ST_TRIM,
        ST_POP_RD,
        ST_POP_TAKE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic load_cutoff;
        logic drop_head;
        logic write_entry;
        logic trim;
        logic pop_take;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic age_hit;
        logic count_nz;
        logic out_busy;
    } sts_t;

endpackage

// ===== hdl/aslf_ctrl.sv =====
// Sequencer for the log FIFO: walks record and pop beats through the datapath.
// Depends on aslf_pkg for state, command and status types.
module aslf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_mode,
    output logic          s_ready,
    input  aslf_pkg::sts_t sts,
    output aslf_pkg::cmd_t cmd
);

    aslf_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aslf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            aslf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = (s_mode == aslf_pkg::MODE_POP) ? aslf_pkg::ST_POP_RD
                                                                 : aslf_pkg::ST_AGE_RD;
                end
            end
            aslf_pkg::ST_AGE_RD: begin
                cmd.load_cutoff = 1'b1;
                state_next      = aslf_pkg::ST_AGE_CMP;
            end
            aslf_pkg::ST_AGE_CMP: begin
                if (sts.age_hit) begin
                    cmd.drop_head = 1'b1;
                    state_next    = aslf_pkg::ST_AGE_RD;
                end else begin
                    state_next = aslf_pkg::ST_STORE;
                end
            end
            aslf_pkg::ST_STORE: begin
                cmd.write_entry = 1'b1;
                state_next      = aslf_pkg::ST_TRIM;
            end
            aslf_pkg::ST_TRIM: begin
                cmd.trim   = 1'b1;
                state_next = aslf_pkg::ST_DONE;
            end
            aslf_pkg::ST_POP_RD: begin
                state_next = aslf_pkg::ST_POP_TAKE;
            end
            aslf_pkg::ST_POP_TAKE: begin
                cmd.pop_take  = 1'b1;
                cmd.drop_head = sts.count_nz;
                state_next    = aslf_pkg::ST_DONE;
            end
            aslf_pkg::ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = aslf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aslf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/aslf_dp.sv =====
// Datapath for the log FIFO: entry memory, head and count, limits and result register.
// Depends on aslf_pkg; driven by aslf_ctrl through command and status structs.
module aslf_dp #(
    parameter int DEPTH     = 512,
    parameter int TIME_BITS = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  aslf_pkg::in_t                     s_data,
    input  logic                              cfg_we,
    input  logic [aslf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aslf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  aslf_pkg::cmd_t                    cmd,
    output aslf_pkg::sts_t                    sts,
    input  logic                              m_ready,
    output logic                              m_valid,
    output aslf_pkg::out_t                    m_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TW    = TIME_BITS;
    localparam int CW    = (TIME_BITS > aslf_pkg::IN_TIME_W) ? TIME_BITS : aslf_pkg::IN_TIME_W;
    localparam int LW    = (CNT_W > aslf_pkg::ENT_W) ? CNT_W : aslf_pkg::ENT_W;
    localparam int HW    = (CNT_W > aslf_pkg::CNT_OUT_W) ? CNT_W : aslf_pkg::CNT_OUT_W;
    localparam int EW    = TW + aslf_pkg::SEQ_W;

    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [CNT_W:0] sum);
        logic [CNT_W:0] r;
        r = sum;
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            r = sum - (CNT_W+1)'(DEPTH);
        end
        return r[PTR_W-1:0];
    endfunction

    logic [EW-1:0] entry_mem [DEPTH];
    logic [EW-1:0] rd_q;

    logic [PTR_W-1:0]                 head_reg, head_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [aslf_pkg::IN_TIME_W-1:0]   max_age_reg;
    logic [aslf_pkg::ENT_W-1:0]       max_ent_reg;
    logic                             m_valid_reg, m_valid_next;

    logic [aslf_pkg::SEQ_W-1:0]       in_seq_reg;
    logic [CW-1:0]                    in_now_reg;
    logic [CW-1:0]                    cutoff_reg;
    logic                             cutoff_ok_reg;
    logic                             popped_reg;
    logic [aslf_pkg::SEQ_W-1:0]       pop_seq_reg;
    logic [CW-1:0]                    pop_time_reg;
    aslf_pkg::out_t                   out_reg, out_next;

    logic [CW-1:0]    now_ext, age_ext, rd_time_ext;
    logic [LW-1:0]    ent_ext, lim_ext;
    logic [CNT_W-1:0] lim;
    logic             full;
    logic [PTR_W-1:0] wr_addr;
    logic [HW-1:0]    held_ext;

    assign now_ext     = CW'(s_data.now_us);
    assign age_ext     = CW'(max_age_reg);
    assign rd_time_ext = CW'(rd_q[EW-1:aslf_pkg::SEQ_W]);
    assign ent_ext     = LW'(max_ent_reg);
    assign full        = (count_reg == CNT_W'(DEPTH));
    assign wr_addr     = full ? head_reg
                              : wrap_ptr((CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg));

    always_comb begin
        priority if (ent_ext == '0) begin
            lim_ext = LW'(1);
        end else if (ent_ext > LW'(DEPTH)) begin
            lim_ext = LW'(DEPTH);
        end else begin
            lim_ext = ent_ext;
        end
    end
    assign lim = lim_ext[CNT_W-1:0];

    assign sts.count_nz = (count_reg != '0);
    assign sts.age_hit  = (count_reg != '0) && cutoff_ok_reg && (rd_time_ext < cutoff_reg);
    assign sts.out_busy = m_valid_reg && !m_ready;

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        priority if (cmd.drop_head) begin
            head_next  = wrap_ptr((CNT_W+1)'(head_reg) + (CNT_W+1)'(1));
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.write_entry) begin
            if (full) begin
                head_next = wrap_ptr((CNT_W+1)'(head_reg) + (CNT_W+1)'(1));
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else if (cmd.trim && (count_reg > lim)) begin
            head_next  = wrap_ptr((CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg - lim));
            count_next = lim;
        end
    end

    assign held_ext = HW'(count_reg);

    always_comb begin
        out_next             = '0;
        out_next.entry_valid = popped_reg;
        out_next.seq_out     = popped_reg ? pop_seq_reg : '0;
        out_next.time_out    = popped_reg ? pop_time_reg[aslf_pkg::IN_TIME_W-1:0] : '0;
        out_next.last_entry  = (count_reg == '0);
        out_next.held_count  = held_ext[aslf_pkg::CNT_OUT_W-1:0];
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            max_age_reg <= aslf_pkg::MAX_AGE_RESET;
            max_ent_reg <= aslf_pkg::MAX_ENTRIES_RESET;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    aslf_pkg::REG_MAX_AGE: begin
                        max_age_reg <= cfg_wdata[aslf_pkg::IN_TIME_W-1:0];
                    end
                    aslf_pkg::REG_MAX_ENTRIES: begin
                        max_ent_reg <= cfg_wdata[aslf_pkg::ENT_W-1:0];
                    end
                    default: begin
                        max_age_reg <= max_age_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_seq_reg <= s_data.seq_in;
            in_now_reg <= CW'(now_ext[TW-1:0]);
            popped_reg <= 1'b0;
        end
        if (cmd.load_cutoff) begin
            cutoff_ok_reg <= (in_now_reg >= age_ext);
            cutoff_reg    <= in_now_reg - age_ext;
        end
        if (cmd.pop_take) begin
            popped_reg   <= (count_reg != '0);
            pop_seq_reg  <= rd_q[aslf_pkg::SEQ_W-1:0];
            pop_time_reg <= rd_time_ext;
        end
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_entry) begin
            entry_mem[wr_addr] <= {in_now_reg[TW-1:0], in_seq_reg};
        end
        rd_q <= entry_mem[head_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== hdl/aged_sequence_log_fifo.sv =====
// Top level of the timestamped log FIFO with age expiry.
// Depends on aslf_pkg, aslf_ctrl and aslf_dp.
//
//   port group   direction  beat contents
//   s_*          in         mode, seq_in, now_us (aslf_pkg::in_t)
//   m_*          out        entry_valid, seq_out, time_out, last_entry, held_count
//   cfg_*        in         register index and write data, no handshake
//
// Pop: POP_RD, POP_TAKE, DONE. Record: AGE_RD and AGE_CMP for each aged-out head entry
// and once more, then STORE, TRIM, DONE; the entry memory has a single registered read.
// Reset clears head and count and loads the limit registers; no memory clearing pass.
// A stalled result is held in the output register; the next beat is taken and
// waits before its result once its work is finished.
module aged_sequence_log_fifo #(
    parameter int DEPTH     = 512,
    parameter int TIME_BITS = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  aslf_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output aslf_pkg::out_t                  m_data,
    input  logic                            cfg_we,
    input  logic [aslf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aslf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    aslf_pkg::cmd_t cmd;
    aslf_pkg::sts_t sts;

    aslf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_data.mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aslf_dp #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a beat is in progress");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_busy)
        else $error("result loaded over a stalled beat");

    a_age_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.age_hit |-> sts.count_nz)
        else $error("ageing flagged on an empty log");

    a_drop_store: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.drop_head && cmd.write_entry))
        else $error("head drop and store in the same cycle");

endmodule
